// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SPOS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");

// condition in one cycle implies a consequence in the next
`define SPOS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle consequence missing");

`endif

// ===== sv/spos_pkg.sv =====
// ----------------------------------------------------------------------------
// spos_pkg
// types, coil tables and elaboration helpers for the stepper angle positioner
// ----------------------------------------------------------------------------
package spos_pkg;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_SET_TARGET = 2'd1,
        ACT_PRESET     = 2'd2,
        ACT_LOAD       = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [7:0]  angle;
        logic [15:0] step_count;
    } t_spos_in;

    typedef struct packed {
        logic [7:0]  coil_pattern;
        logic        stepped;
        logic        counter_clockwise;
        logic [7:0]  actual_angle;
        logic [15:0] steps_left;
    } t_spos_out;

    localparam logic [7:0] COILS_OFF        = 8'h00;
    localparam logic [7:0] DIVIDER_RESET    = 8'd5;
    localparam logic [7:0] CW_TABLE  [4]    = '{8'h50, 8'h60, 8'hA0, 8'h90};
    localparam logic [7:0] CCW_TABLE [4]    = '{8'h90, 8'hA0, 8'h60, 8'h50};

    // count of trailing zero bits
    function automatic int spos_ctz(input logic [7:0] d);
        int   tz;
        logic found;
        tz    = 0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && !d[i]) begin
                tz = tz + 1;
            end else begin
                found = 1'b1;
            end
        end
        return tz;
    endfunction

    // multiplicative inverse of an odd value modulo 2^16 (newton iteration)
    function automatic logic [15:0] spos_inv16(input logic [15:0] d);
        logic [15:0] x;
        x = d;
        for (int i = 0; i < 4; i++) begin
            x = x * (16'd2 - d * x);
        end
        return x;
    endfunction

endpackage

// ===== sv/spos_stream_if.sv =====
// ----------------------------------------------------------------------------
// spos_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface spos_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/stepper_angle_positioner.sv =====
// ----------------------------------------------------------------------------
// stepper_angle_positioner
// Takes one item per clock cycle unless the output stalls: the tick, target,
// preset and load items update the drive state in a single combinational
// pass and the result is written to an output register on the transfer. The
// input is ready whenever the output register is empty or being drained in
// the same cycle, so with an always-ready sink the block sustains one item
// per cycle. Divisibility of the step count by DEGREE_STEPS is tested with
// one 16x16 multiply by the modular inverse of its odd part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_angle_positioner #(
    parameter int DEGREE_STEPS = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    spos_stream_if.sink   i_in,
    spos_stream_if.source o_out
);
    import spos_pkg::*;

    localparam int          DEG_TZ    = spos_ctz(8'(DEGREE_STEPS));
    localparam logic [15:0] DEG_INV   = spos_inv16(16'(DEGREE_STEPS >> DEG_TZ));
    localparam logic [15:0] DEG_LIMIT = 16'(32'hFFFF / DEGREE_STEPS);

    logic [7:0]  r_divider;
    logic [7:0]  r_prescaler, n_prescaler;
    logic [1:0]  r_phase,     n_phase;
    logic [7:0]  r_target,    n_target;
    logic [7:0]  r_position,  n_position;
    logic [15:0] r_remaining, n_remaining;
    logic        r_ccw,       n_ccw;
    logic [7:0]  r_drive,     n_drive;
    logic        n_stepped;
    logic        r_out_valid;
    t_spos_out   r_out;

    logic        w_in_xfer;
    logic [15:0] w_next_rem;
    logic [15:0] w_prod;
    logic [15:0] w_rot;
    logic        w_on_degree;
    logic [7:0]  w_diff;
    logic [15:0] w_reload;
    logic        w_step_ccw;

    // no transfer is taken while reset is held
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_in_xfer  = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // exact divisibility test: rotate(v * inv(odd part)) <= floor(max / d)
    assign w_next_rem  = r_remaining - 16'd1;
    assign w_prod      = w_next_rem * DEG_INV;
    assign w_rot       = (w_prod >> DEG_TZ) | (w_prod << (16 - DEG_TZ));
    assign w_on_degree = (w_rot <= DEG_LIMIT);

    assign w_diff   = (r_position < i_in.data.angle) ? (i_in.data.angle - r_position)
                                                     : (r_position - i_in.data.angle);
    assign w_reload = {8'd0, w_diff} * 16'(DEGREE_STEPS);

    assign w_step_ccw = (r_position > r_target);

    always_comb begin
        n_prescaler = r_prescaler;
        n_phase     = r_phase;
        n_target    = r_target;
        n_position  = r_position;
        n_remaining = r_remaining;
        n_ccw       = r_ccw;
        n_drive     = r_drive;
        n_stepped   = 1'b0;
        unique case (i_in.data.action)
            ACT_TICK: begin
                n_prescaler = r_prescaler + 8'd1;
                if (n_prescaler == r_divider) begin
                    n_prescaler = 8'd0;
                    if (r_position != r_target) begin
                        n_stepped   = 1'b1;
                        n_ccw       = w_step_ccw;
                        n_drive     = w_step_ccw ? CCW_TABLE[r_phase] : CW_TABLE[r_phase];
                        n_phase     = r_phase + 2'd1;
                        n_remaining = w_next_rem;
                        if (w_on_degree) begin
                            n_position = w_step_ccw ? (r_position - 8'd1)
                                                    : (r_position + 8'd1);
                        end
                    end else begin
                        n_drive = COILS_OFF;
                        n_phase = 2'd0;
                    end
                end
            end
            ACT_SET_TARGET: begin
                if (i_in.data.angle != r_target) begin
                    n_target = i_in.data.angle;
                    if (i_in.data.angle != r_position) begin
                        n_remaining = w_reload;
                    end
                end
            end
            ACT_PRESET: begin
                n_position = i_in.data.angle;
            end
            ACT_LOAD: begin
                n_remaining = i_in.data.step_count;
            end
            default: begin
                n_stepped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider   <= DIVIDER_RESET;
            r_prescaler <= 8'd0;
            r_phase     <= 2'd0;
            r_target    <= 8'd0;
            r_position  <= 8'd0;
            r_remaining <= 16'd0;
            r_ccw       <= 1'b0;
            r_drive     <= COILS_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_divider <= i_cfg_wdata;
            end
            if (w_in_xfer) begin
                r_prescaler <= n_prescaler;
                r_phase     <= n_phase;
                r_target    <= n_target;
                r_position  <= n_position;
                r_remaining <= n_remaining;
                r_ccw       <= n_ccw;
                r_drive     <= n_drive;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out.coil_pattern      <= n_drive;
            r_out.stepped           <= n_stepped;
            r_out.counter_clockwise <= n_ccw;
            r_out.actual_angle      <= n_position;
            r_out.steps_left        <= n_remaining;
        end
    end

    `SPOS_ASSERT_NEXT(a_xfer_fills_result, i_clk, i_rst_n, w_in_xfer, r_out_valid)
    `SPOS_ASSERT(a_step_drives_coils, i_clk, i_rst_n,
                 (r_out_valid && r_out.stepped) |-> (r_out.coil_pattern != COILS_OFF))
    `SPOS_ASSERT_NEXT(a_step_counts_down, i_clk, i_rst_n, w_in_xfer && n_stepped,
                      r_remaining == $past(r_remaining) - 16'd1)
    `SPOS_ASSERT_NEXT(a_command_no_step, i_clk, i_rst_n,
                      w_in_xfer && (i_in.data.action != ACT_TICK), !r_out.stepped)

endmodule

// ===== test/tb_stepper_angle_positioner.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_angle_positioner
// Drives tick, target, preset and load items through the input channel while
// an in-bench model of the drive state predicts every result. Results are
// checked field by field in transfer order. The run covers several divider
// settings and phases of sender idling, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_stepper_angle_positioner;
    timeunit 1ns;
    timeprecision 1ps;

    import spos_pkg::*;

    localparam int DEGREE_STEPS = 17;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 3;

    // ------------------------------------------------------------------------
    // drive state model and store of expected results
    // ------------------------------------------------------------------------
    class spos_scoreboard;
        logic [7:0]  divider   = DIVIDER_RESET;
        logic [7:0]  prescaler = '0;
        logic [1:0]  phase     = '0;
        logic [7:0]  target    = '0;
        logic [7:0]  position  = '0;
        logic [15:0] remaining = '0;
        logic        ccw       = 1'b0;
        logic [7:0]  drive     = COILS_OFF;
        t_spos_out   drive_q[$];
        int          failures  = 0;

        function void set_divider(logic [7:0] value);
            divider = value;
        endfunction

        function void motor_step(logic dir_ccw);
            ccw       = dir_ccw;
            drive     = dir_ccw ? CCW_TABLE[phase] : CW_TABLE[phase];
            phase     = phase + 2'd1;
            remaining = remaining - 16'd1;
            if (remaining % DEGREE_STEPS == 0) begin
                position = dir_ccw ? position - 8'd1 : position + 8'd1;
            end
        endfunction

        function void note_input(t_spos_in it);
            t_spos_out   res;
            logic [15:0] diff;
            res.stepped = 1'b0;
            case (it.action)
                ACT_TICK: begin
                    prescaler = prescaler + 8'd1;
                    if (prescaler == divider) begin
                        prescaler = '0;
                        if (position < target) begin
                            motor_step(1'b0);
                            res.stepped = 1'b1;
                        end else if (position > target) begin
                            motor_step(1'b1);
                            res.stepped = 1'b1;
                        end else begin
                            drive = COILS_OFF;
                            phase = '0;
                        end
                    end
                end
                ACT_SET_TARGET: begin
                    if (it.angle != target) begin
                        target = it.angle;
                        if (position != target) begin
                            diff = (position < target) ? {8'd0, target - position}
                                                       : {8'd0, position - target};
                            remaining = 16'(diff * DEGREE_STEPS);
                        end
                    end
                end
                ACT_PRESET: begin
                    position = it.angle;
                end
                default: begin
                    remaining = it.step_count;
                end
            endcase
            res.coil_pattern      = drive;
            res.counter_clockwise = ccw;
            res.actual_angle      = position;
            res.steps_left        = remaining;
            drive_q.push_back(res);
        endfunction

        function void check_result(t_spos_out got);
            t_spos_out want;
            if (drive_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: pattern %h angle %0d steps %0d",
                             got.coil_pattern, got.actual_angle, got.steps_left);
                end
                return;
            end
            want = drive_q.pop_front();
            if (got.coil_pattern !== want.coil_pattern || got.stepped !== want.stepped ||
                got.counter_clockwise !== want.counter_clockwise ||
                got.actual_angle !== want.actual_angle ||
                got.steps_left !== want.steps_left) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected pattern %h stepped %b ccw %b angle %0d steps %0d",
                             want.coil_pattern, want.stepped, want.counter_clockwise,
                             want.actual_angle, want.steps_left);
                    $display("          actual   pattern %h stepped %b ccw %b angle %0d steps %0d",
                             got.coil_pattern, got.stepped, got.counter_clockwise,
                             got.actual_angle, got.steps_left);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    spos_stream_if #(.T(t_spos_in))  in_if ();
    spos_stream_if #(.T(t_spos_out)) out_if ();

    stepper_angle_positioner #(
        .DEGREE_STEPS (DEGREE_STEPS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    spos_scoreboard sb = new;
    int idle_pct    = 0;
    int stall_pct   = 0;
    logic hold_active = 1'b0;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stepper_angle_positioner test failed");
            $finish;
        end
    end

    // transfers are observed on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_input(in_if.data);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.data);
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !hold_active && ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic t_spos_in mk_item(t_action act, logic [7:0] ang, logic [15:0] cnt);
        t_spos_in it;
        it.action     = act;
        it.angle      = ang;
        it.step_count = cnt;
        return it;
    endfunction

    // mostly ticks, with targets mostly kept near the tracked angle so moves complete
    function automatic t_spos_in rand_item();
        int          r;
        logic [7:0]  ang;
        logic [15:0] cnt;
        t_action     act;
        r   = $urandom_range(0, 99);
        ang = ($urandom_range(0, 9) < 7) ? sb.position + 8'($urandom_range(0, 8)) - 8'd4
                                         : 8'($urandom_range(0, 255));
        cnt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40))
                                          : 16'($urandom_range(0, 65535));
        if (r < 80) begin
            act = ACT_TICK;
            ang = 8'($urandom_range(0, 255));
        end else if (r < 90) begin
            act = ACT_SET_TARGET;
        end else if (r < 95) begin
            act = ACT_PRESET;
        end else begin
            act = ACT_LOAD;
        end
        return mk_item(act, ang, cnt);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(t_spos_in it);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(mk_item(ACT_TICK, 8'($urandom_range(0, 255)),
                                     16'($urandom_range(0, 65535))));
    endtask

    // hold the sender until every expected result is back, then let it settle
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_divider(logic [7:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_divider(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    logic [7:0] phase_div [5];
    int         phase_len [5] = '{110, 130, 130, 110, 90};
    int         phase_idle[5] = '{0, 86, 0, 26, 0};
    int         phase_stall[5] = '{0, 0, 86, 26, 0};

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset divider: coils off at the target, then one clockwise step
        send_ticks(5);
        send_item(mk_item(ACT_SET_TARGET, 8'd3, 16'h0000));
        send_item(mk_item(ACT_SET_TARGET, 8'd3, 16'hFFFF));
        send_ticks(5);
        send_item(mk_item(ACT_PRESET, 8'd3, 16'h0000));
        // zero count wraps on the next step
        send_item(mk_item(ACT_LOAD, 8'hFF, 16'h0000));
        send_item(mk_item(ACT_PRESET, 8'd0, 16'hFFFF));
        send_ticks(5);

        write_divider(8'd1);
        send_item(mk_item(ACT_PRESET, 8'hFF, 16'h0000));
        send_item(mk_item(ACT_SET_TARGET, 8'h00, 16'h0000));
        send_ticks(3);
        send_item(mk_item(ACT_LOAD, 8'h00, 16'hFFFF));
        send_ticks(2);
        // new target equal to the tracked angle leaves the count alone
        send_item(mk_item(ACT_PRESET, 8'd7, 16'h0000));
        send_item(mk_item(ACT_SET_TARGET, 8'd7, 16'h0000));
        send_ticks(1);

        // the zero divider follows 255 so the prescaler wraps through it
        phase_div = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(1, 6))};
        for (int p = 0; p < 5; p++) begin
            write_divider(phase_div[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == 4) begin
                fork
                    begin
                        @(posedge i_clk);
                        hold_active = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_active = 1'b0;
                    end
                join_none
            end
            repeat (phase_len[p]) send_item(rand_item());
        end

        wait_drained();
        if (sb.failures == 0 && sb.drive_q.size() == 0) begin
            $display("stepper_angle_positioner test passed");
        end else begin
            $display("stepper_angle_positioner test failed");
        end
        $finish;
    end
endmodule

// ===== stepper_angle_positioner.f =====
+incdir+sv
sv/spos_pkg.sv
sv/spos_stream_if.sv
sv/stepper_angle_positioner.sv
test/tb_stepper_angle_positioner.sv
